>>> hw/rtl/mnt_pkg.sv
`default_nettype none

package mnt_pkg;

   typedef logic [3:0] cell_idx_type [16];

   typedef struct packed {
      logic        valid;
      logic [63:0] state;
      logic [63:0] tweak;
   } stage_type;

   typedef enum logic [1:0] {
      CSR_KEY_LOW      = 2'd0,
      CSR_KEY_HIGH     = 2'd1,
      CSR_ROUND_COUNT  = 2'd2,
      CSR_DECRYPT_MODE = 2'd3
   } csr_index_type;

   localparam int unsigned MAX_ROUNDS = 8;
   localparam logic [3:0] MIN_ROUND_COUNT = 4'd5;
   localparam logic [3:0] MAX_ROUND_COUNT = 4'd8;
   localparam logic [3:0] RESET_ROUND_COUNT = 4'd7;

   localparam logic [63:0] ALPHA = 64'h243F6A8885A308D3;

   localparam logic [63:0] ROUND_CONST [MAX_ROUNDS] = '{
      64'h13198A2E03707344, 64'hA4093822299F31D0,
      64'h082EFA98EC4E6C89, 64'h452821E638D01377,
      64'hBE5466CF34E90C6C, 64'hC0AC29B7C97C50DD,
      64'h3F84D5B5B5470917, 64'h9216D5D98979FB1B
   };

   localparam cell_idx_type SBOX = '{
      4'hC, 4'hA, 4'hD, 4'h3, 4'hE, 4'hB, 4'hF, 4'h7,
      4'h8, 4'h9, 4'h1, 4'h5, 4'h0, 4'h2, 4'h4, 4'h6
   };

   // new cell i = old cell table[i]
   localparam cell_idx_type PERM_FWD = '{
      4'd0, 4'd11, 4'd6, 4'd13, 4'd10, 4'd1, 4'd12, 4'd7,
      4'd5, 4'd14, 4'd3, 4'd8, 4'd15, 4'd4, 4'd9, 4'd2
   };
   localparam cell_idx_type PERM_INV = '{
      4'd0, 4'd5, 4'd15, 4'd10, 4'd13, 4'd8, 4'd2, 4'd7,
      4'd11, 4'd14, 4'd4, 4'd1, 4'd6, 4'd3, 4'd9, 4'd12
   };
   localparam cell_idx_type TWK_FWD = '{
      4'd6, 4'd5, 4'd14, 4'd15, 4'd0, 4'd1, 4'd2, 4'd3,
      4'd7, 4'd12, 4'd13, 4'd4, 4'd8, 4'd9, 4'd10, 4'd11
   };
   localparam cell_idx_type TWK_INV = '{
      4'd4, 4'd5, 4'd6, 4'd7, 4'd11, 4'd1, 4'd0, 4'd8,
      4'd12, 4'd13, 4'd14, 4'd15, 4'd9, 4'd10, 4'd2, 4'd3
   };

   // cell 0 is the most significant nibble
   function automatic logic [63:0] permute_cells(input logic [63:0] w,
                                                 input cell_idx_type tab);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < 16; i++) begin
         r[63 - 4 * i -: 4] = w[63 - 4 * int'(tab[i]) -: 4];
      end
      return r;
   endfunction

   function automatic logic [63:0] sub_cells(input logic [63:0] w);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < 16; i++) begin
         r[63 - 4 * i -: 4] = SBOX[w[63 - 4 * i -: 4]];
      end
      return r;
   endfunction

   // each 16-bit row becomes the XOR of the other three rows
   function automatic logic [63:0] mix_columns(input logic [63:0] w);
      logic [15:0] r0;
      logic [15:0] r1;
      logic [15:0] r2;
      logic [15:0] r3;
      r0 = w[63:48];
      r1 = w[47:32];
      r2 = w[31:16];
      r3 = w[15:0];
      return {r1 ^ r2 ^ r3, r0 ^ r2 ^ r3, r0 ^ r1 ^ r3, r0 ^ r1 ^ r2};
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tweakable_block_cipher_64.sv
// Pipeline registers, in order: entry whitening, eight forward round stages,
// middle layer, eight reverse round stages, output whitening.
// Throughput: one block per cycle; busy stays low. Rounds beyond round_count,
// clamped to 5..8, pass through unchanged; latency does not depend on it.
// Reset clears the pipeline valid bits and returns the keys to zero,
// round_count to 7 and decrypt_mode to 0. The receiver cannot stall.
`default_nettype none

module tweakable_block_cipher_64
   import mnt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [63:0] req_data_block,
   input  wire logic [63:0] req_tweak_value,
   output      logic        rsp_valid,
   output      logic [63:0] rsp_result_block,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_write_data
);

   logic [63:0] key_low_ff;
   logic [63:0] key_high_ff;
   logic [3:0]  round_count_ff;
   logic        decrypt_mode_ff;

   logic [63:0] k0;
   logic [63:0] k0_prime;
   logic [63:0] k1;
   logic [63:0] k1_alpha;
   logic [63:0] k0_rot;
   logic [3:0]  rounds;

   logic        entry_valid_ff;
   logic [63:0] entry_state_ff;
   logic [63:0] entry_tweak_ff;
   logic        mid_valid_ff;
   logic [63:0] mid_state_ff;
   logic [63:0] mid_tweak_ff;
   logic        out_valid_ff;
   logic [63:0] out_block_ff;

   stage_type   fwd_chain [MAX_ROUNDS + 1];
   stage_type   inv_chain [MAX_ROUNDS + 1];

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff      <= '0;
         key_high_ff     <= '0;
         round_count_ff  <= RESET_ROUND_COUNT;
         decrypt_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_LOW:      key_low_ff      <= csr_write_data;
            CSR_KEY_HIGH:     key_high_ff     <= csr_write_data;
            CSR_ROUND_COUNT:  round_count_ff  <= csr_write_data[3:0];
            CSR_DECRYPT_MODE: decrypt_mode_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // key setup
   always_comb begin
      k0_rot = {key_low_ff[0], key_low_ff[63:1]} ^ {63'd0, key_low_ff[63]};
      if (decrypt_mode_ff) begin
         k0       = k0_rot;
         k0_prime = key_low_ff;
         k1       = key_high_ff ^ ALPHA;
      end else begin
         k0       = key_low_ff;
         k0_prime = k0_rot;
         k1       = key_high_ff;
      end
      k1_alpha = k1 ^ ALPHA;
      if (round_count_ff < MIN_ROUND_COUNT) begin
         rounds = MIN_ROUND_COUNT;
      end else if (round_count_ff > MAX_ROUND_COUNT) begin
         rounds = MAX_ROUND_COUNT;
      end else begin
         rounds = round_count_ff;
      end
   end

   assign busy = 1'b0;

   // entry whitening
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      entry_state_ff <= req_data_block ^ k0 ^ k1 ^ req_tweak_value;
      entry_tweak_ff <= req_tweak_value;
   end

   assign fwd_chain[0] = '{valid: entry_valid_ff, state: entry_state_ff,
                           tweak: entry_tweak_ff};

   for (genvar i = 0; i < MAX_ROUNDS; i++) begin : g_fwd
      mnt_fwd_round u_round (
         .clock       (clock),
         .reset       (reset),
         .active      (4'(i) < rounds),
         .round_key   (k1),
         .round_const (ROUND_CONST[i]),
         .stage_in    (fwd_chain[i]),
         .stage_out   (fwd_chain[i + 1])
      );
   end

   // middle layer
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= fwd_chain[MAX_ROUNDS].valid;
      end
   end

   always_ff @(posedge clock) begin
      mid_state_ff <= sub_cells(mix_columns(sub_cells(fwd_chain[MAX_ROUNDS].state)));
      mid_tweak_ff <= fwd_chain[MAX_ROUNDS].tweak;
   end

   assign inv_chain[0] = '{valid: mid_valid_ff, state: mid_state_ff,
                           tweak: mid_tweak_ff};

   for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_inv
      mnt_inv_round u_round (
         .clock       (clock),
         .reset       (reset),
         .active      (4'(MAX_ROUNDS - 1 - k) < rounds),
         .round_key   (k1_alpha),
         .round_const (ROUND_CONST[MAX_ROUNDS - 1 - k]),
         .stage_in    (inv_chain[k]),
         .stage_out   (inv_chain[k + 1])
      );
   end

   // output whitening
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= inv_chain[MAX_ROUNDS].valid;
      end
   end

   always_ff @(posedge clock) begin
      out_block_ff <= inv_chain[MAX_ROUNDS].state ^ k0_prime ^ k1_alpha
                      ^ inv_chain[MAX_ROUNDS].tweak;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_block = out_block_ff;

endmodule

`default_nettype wire

>>> hw/rtl/mnt_fwd_round.sv
`default_nettype none

module mnt_fwd_round
   import mnt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        active,
   input  wire logic [63:0] round_key,
   input  wire logic [63:0] round_const,
   input  wire stage_type   stage_in,
   output stage_type        stage_out
);

   logic        valid_ff;
   logic [63:0] state_ff;
   logic [63:0] tweak_ff;
   logic [63:0] state_in;
   logic [63:0] tweak_in;
   logic [63:0] tweak_next;
   logic [63:0] keyed;

   always_comb begin
      tweak_next = permute_cells(stage_in.tweak, TWK_FWD);
      keyed      = sub_cells(stage_in.state) ^ round_const ^ round_key ^ tweak_next;
      if (active) begin
         state_in = mix_columns(permute_cells(keyed, PERM_FWD));
         tweak_in = tweak_next;
      end else begin
         state_in = stage_in.state;
         tweak_in = stage_in.tweak;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      tweak_ff <= tweak_in;
   end

   assign stage_out = '{valid: valid_ff, state: state_ff, tweak: tweak_ff};

endmodule

`default_nettype wire

>>> hw/rtl/mnt_inv_round.sv
`default_nettype none

module mnt_inv_round
   import mnt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        active,
   input  wire logic [63:0] round_key,
   input  wire logic [63:0] round_const,
   input  wire stage_type   stage_in,
   output stage_type        stage_out
);

   logic        valid_ff;
   logic [63:0] state_ff;
   logic [63:0] tweak_ff;
   logic [63:0] state_in;
   logic [63:0] tweak_in;
   logic [63:0] keyed;

   always_comb begin
      keyed = permute_cells(mix_columns(stage_in.state), PERM_INV)
              ^ round_key ^ stage_in.tweak ^ round_const;
      if (active) begin
         state_in = sub_cells(keyed);
         tweak_in = permute_cells(stage_in.tweak, TWK_INV);
      end else begin
         state_in = stage_in.state;
         tweak_in = stage_in.tweak;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      tweak_ff <= tweak_in;
   end

   assign stage_out = '{valid: valid_ff, state: state_ff, tweak: tweak_ff};

endmodule

`default_nettype wire
